[rtl/core/gcb_pkg.sv]
// gcb_pkg: shared constants, CSR codes and the CORDIC arctangent table
// for the great-circle bearing pipeline. No dependencies.
package gcb_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int FRAC_BITS_DEF    = 24;

   // angles in 1e-7 degree
   localparam int ANG_W = 32;
   localparam int VZ_W  = 33;
   localparam logic signed [VZ_W-1:0] DEG90  = 33'sd900000000;
   localparam logic signed [VZ_W-1:0] DEG180 = 33'sd1800000000;
   localparam logic signed [VZ_W-1:0] DEG360 = 33'sd3600000000;

   // 1/K of the CORDIC, Q32
   localparam logic [63:0] INV_GAIN_Q32 = 64'd2608131496;

   // divide by 1e5 = 2^5 * 3125, the 3125 by reciprocal and one correction
   localparam logic signed [VZ_W:0] ROUND_HALF = 34'sd50000;
   localparam int                   DIV_PRE    = 5;
   localparam int                   DIV_M_W    = 27;
   localparam int                   DIV_K_W    = 28;
   localparam int                   DIV_P_W    = DIV_M_W + DIV_K_W;
   localparam int                   DIV_SHIFT  = 39;
   localparam logic [DIV_K_W-1:0]   DIV_MUL    = 28'd175921860;
   localparam logic [DIV_M_W-1:0]   DIV_RADIX  = 27'd3125;
   localparam logic [15:0]          AZ_WRAP    = 16'd36000;

   typedef enum logic [1:0] {
      CSR_BASE_LAT = 2'd0,
      CSR_BASE_LON = 2'd1
   } csr_index_type;

   function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0:  v = 32'sd450000000;
         1:  v = 32'sd265650512;
         2:  v = 32'sd140362435;
         3:  v = 32'sd71250163;
         4:  v = 32'sd35763344;
         5:  v = 32'sd17899106;
         6:  v = 32'sd8951737;
         7:  v = 32'sd4476142;
         8:  v = 32'sd2238105;
         9:  v = 32'sd1119057;
         10: v = 32'sd559529;
         11: v = 32'sd279765;
         12: v = 32'sd139882;
         13: v = 32'sd69941;
         14: v = 32'sd34971;
         15: v = 32'sd17485;
         16: v = 32'sd8743;
         17: v = 32'sd4371;
         18: v = 32'sd2186;
         19: v = 32'sd1093;
         20: v = 32'sd546;
         21: v = 32'sd273;
         22: v = 32'sd137;
         23: v = 32'sd68;
         24: v = 32'sd34;
         25: v = 32'sd17;
         26: v = 32'sd9;
         27: v = 32'sd4;
         28: v = 32'sd2;
         29: v = 32'sd1;
         30: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/great_circle_bearing.sv]
// great_circle_bearing: pipelined initial great-circle bearing from a
// base position (CSRs) to a target position. Depends on gcb_pkg.
//
// Usage:
//  - CSR port: csr_wr_en with csr_index 0 (base latitude) or 1 (base
//    longitude) and csr_wdata; other indexes are ignored. Write only while
//    the pipeline is empty.
//  - Request channel (req_*): one target position per request, accepted
//    when req_valid is high and req_stall is low.
//  - Response channel (rsp_*): one azimuth per request, in order,
//    0..35999 hundredths of a degree clockwise from north.
//  - Pipeline: two CORDIC chains, one iteration per stage: three
//    sine/cosine rotations side by side, then one atan2 vectoring chain,
//    plus input, wrap, fold, three multiply, half-turn, two divide and
//    output stages.
//  - Throughput: one request per cycle while the pipeline is not stalled.
//  - Stall: when rsp_stall holds a valid response, the whole pipeline
//    freezes and req_stall is raised; nothing is lost or repeated.
//  - Reset: synchronous; clears all stage valid bits and both base
//    registers to zero.
module great_circle_bearing #(
   parameter int CORDIC_STEPS = gcb_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = gcb_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [30:0]  req_target_latitude,
   input  logic signed [31:0]  req_target_longitude,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_azimuth_centideg
);
   import gcb_pkg::*;

   localparam int W   = FRAC_BITS + 3;   // sin/cos and products
   localparam int VW  = FRAC_BITS + 5;   // vectoring vector, gain headroom
   localparam int PW  = 2 * W;
   localparam int S   = CORDIC_STEPS;
   localparam int LAT = 2 * S + 10;

   localparam logic [63:0] X0_WIDE =
      (INV_GAIN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic signed [W-1:0]  X0  = X0_WIDE[W-1:0];
   localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

   // ---------------- CSRs ----------------
   logic signed [30:0] base_lat_ff;
   logic signed [31:0] base_lon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_lat_ff <= '0;
         base_lon_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_LAT: base_lat_ff <= csr_wdata[30:0];
            CSR_BASE_LON: base_lon_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- valid chain / flow control ----------------
   logic [LAT-1:0] vld_ff;
   logic           pipe_en;
   logic           req_accept;

   assign pipe_en    = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall  = !pipe_en;
   assign req_accept = req_valid && pipe_en;
   assign rsp_valid  = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_accept};
      end
   end

   // ---------------- stage 0: input register ----------------
   logic signed [30:0] lat2_s0_ff;
   logic signed [31:0] lon2_s0_ff;

   // ---------------- stage 1: dLon wrapped to [-180, 180) ----------------
   logic signed [VZ_W-1:0] dl_raw;
   logic signed [VZ_W-1:0] dl_in;
   logic signed [30:0]     lat2_s1_ff;
   logic signed [31:0]     dlon_s1_ff;
   logic                   coin_s1_ff;

   assign dl_raw = VZ_W'(lon2_s0_ff) - VZ_W'(base_lon_ff);

   always_comb begin
      if (dl_raw >= DEG180) begin
         dl_in = dl_raw - DEG360;
      end else if (dl_raw < -DEG180) begin
         dl_in = dl_raw + DEG360;
      end else begin
         dl_in = dl_raw;
      end
   end

   // ---------------- stage 2: fold to [-90, 90] ----------------
   // unit 0: base latitude, 1: target latitude, 2: dLon
   logic signed [ANG_W-1:0] fold_src [0:2];
   logic signed [ANG_W-1:0] fold_ang [0:2];
   logic                    fold_neg [0:2];

   assign fold_src[0] = ANG_W'(base_lat_ff);
   assign fold_src[1] = ANG_W'(lat2_s1_ff);
   assign fold_src[2] = dlon_s1_ff;

   always_comb begin
      for (int u = 0; u < 3; u++) begin
         if (VZ_W'(fold_src[u]) > DEG90) begin
            fold_ang[u] = ANG_W'(VZ_W'(fold_src[u]) - DEG180);
            fold_neg[u] = 1'b1;
         end else if (VZ_W'(fold_src[u]) < -DEG90) begin
            fold_ang[u] = ANG_W'(VZ_W'(fold_src[u]) + DEG180);
            fold_neg[u] = 1'b1;
         end else begin
            fold_ang[u] = fold_src[u];
            fold_neg[u] = 1'b0;
         end
      end
   end

   // ---------------- rotation CORDICs, one iteration per stage ----------------
   logic signed [W-1:0]     rx_ff   [0:2][0:S];
   logic signed [W-1:0]     ry_ff   [0:2][0:S];
   logic signed [ANG_W-1:0] rz_ff   [0:2][0:S];
   logic                    rneg_ff [0:2][0:S];
   logic                    rzero_ff [0:S];

   // signed sin/cos after the fold correction
   logic signed [W-1:0] sn [0:2];
   logic signed [W-1:0] cs [0:2];

   always_comb begin
      for (int u = 0; u < 3; u++) begin
         sn[u] = rneg_ff[u][S] ? -ry_ff[u][S] : ry_ff[u][S];
         cs[u] = rneg_ff[u][S] ? -rx_ff[u][S] : rx_ff[u][S];
      end
   end

   // ---------------- products ----------------
   // x = sd*c2, a = c1*s2, b = s1*c2, then b*cd, then y = a - b*cd
   logic signed [PW-1:0] px_in, pa_in, pb_in, pbc_in;
   logic signed [W-1:0]  mx1_ff, ma1_ff, mb1_ff, mcd1_ff;
   logic signed [W-1:0]  mx2_ff, ma2_ff, mbc2_ff;
   logic signed [W-1:0]  mx3_ff, my3_ff;
   logic                 mzero1_ff, mzero2_ff, mzero3_ff;

   assign px_in  = sn[2] * cs[1] + RND;
   assign pa_in  = cs[0] * sn[1] + RND;
   assign pb_in  = sn[0] * cs[1] + RND;
   assign pbc_in = mb1_ff * mcd1_ff + RND;

   // ---------------- vectoring CORDIC (atan2) ----------------
   logic signed [VW-1:0]   vu_ff [0:S];
   logic signed [VW-1:0]   vv_ff [0:S];
   logic signed [VZ_W-1:0] vz_ff [0:S];
   logic                   vzero_ff [0:S];
   logic signed [VW-1:0]   x3_ext, y3_ext;

   assign x3_ext = VW'(mx3_ff);
   assign y3_ext = VW'(my3_ff);

   // ---------------- final: [0,360) and /1e5 rounded ----------------
   logic signed [VZ_W:0]  fr_in;
   logic [DIV_M_W-1:0]    fm1_ff, fm2_ff;
   logic                  fzero1_ff, fzero2_ff;
   logic [DIV_P_W-1:0]    fp2_ff;
   logic [15:0]           q0;
   logic [DIV_M_W-1:0]    rem;
   logic [15:0]           q1;
   logic [15:0]           az_in;
   logic [15:0]           az_ff;

   assign fr_in = (VZ_W + 1)'(vz_ff[S])
                + (vz_ff[S] < 0 ? (VZ_W + 1)'(DEG360) : '0)
                + ROUND_HALF;

   assign q0  = fp2_ff[DIV_P_W-1 -: 16];
   assign rem = fm2_ff - DIV_M_W'(DIV_M_W'(q0) * DIV_RADIX);

   always_comb begin
      q1 = (rem >= DIV_RADIX) ? q0 + 16'd1 : q0;
      if (fzero2_ff || q1 >= AZ_WRAP) begin
         az_in = '0;
      end else begin
         az_in = q1;
      end
   end

   assign rsp_azimuth_centideg = az_ff;

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lat2_s0_ff <= req_target_latitude;
         lon2_s0_ff <= req_target_longitude;

         lat2_s1_ff <= lat2_s0_ff;
         dlon_s1_ff <= dl_in[ANG_W-1:0];
         coin_s1_ff <= (lat2_s0_ff == base_lat_ff) && (dl_in == '0);

         for (int u = 0; u < 3; u++) begin
            rx_ff[u][0]   <= X0;
            ry_ff[u][0]   <= '0;
            rz_ff[u][0]   <= fold_ang[u];
            rneg_ff[u][0] <= fold_neg[u];
         end
         rzero_ff[0] <= coin_s1_ff;

         for (int k = 0; k < S; k++) begin
            for (int u = 0; u < 3; u++) begin
               if (!rz_ff[u][k][ANG_W-1]) begin
                  rx_ff[u][k+1] <= rx_ff[u][k] - (ry_ff[u][k] >>> k);
                  ry_ff[u][k+1] <= ry_ff[u][k] + (rx_ff[u][k] >>> k);
                  rz_ff[u][k+1] <= rz_ff[u][k] - atan_tab(k);
               end else begin
                  rx_ff[u][k+1] <= rx_ff[u][k] + (ry_ff[u][k] >>> k);
                  ry_ff[u][k+1] <= ry_ff[u][k] - (rx_ff[u][k] >>> k);
                  rz_ff[u][k+1] <= rz_ff[u][k] + atan_tab(k);
               end
               rneg_ff[u][k+1] <= rneg_ff[u][k];
            end
            rzero_ff[k+1] <= rzero_ff[k];
         end

         mx1_ff    <= px_in[FRAC_BITS +: W];
         ma1_ff    <= pa_in[FRAC_BITS +: W];
         mb1_ff    <= pb_in[FRAC_BITS +: W];
         mcd1_ff   <= cs[2];
         mzero1_ff <= rzero_ff[S];

         mx2_ff    <= mx1_ff;
         ma2_ff    <= ma1_ff;
         mbc2_ff   <= pbc_in[FRAC_BITS +: W];
         mzero2_ff <= mzero1_ff;

         mx3_ff    <= mx2_ff;
         my3_ff    <= ma2_ff - mbc2_ff;
         mzero3_ff <= mzero2_ff;

         // south-pointing vector: turn by 180 degrees first
         if (my3_ff < 0) begin
            vu_ff[0] <= -y3_ext;
            vv_ff[0] <= -x3_ext;
            vz_ff[0] <= DEG180;
         end else begin
            vu_ff[0] <= y3_ext;
            vv_ff[0] <= x3_ext;
            vz_ff[0] <= '0;
         end
         vzero_ff[0] <= mzero3_ff || ((mx3_ff == '0) && (my3_ff == '0));

         for (int k = 0; k < S; k++) begin
            if (!vv_ff[k][VW-1]) begin
               vu_ff[k+1] <= vu_ff[k] + (vv_ff[k] >>> k);
               vv_ff[k+1] <= vv_ff[k] - (vu_ff[k] >>> k);
               vz_ff[k+1] <= vz_ff[k] + VZ_W'(atan_tab(k));
            end else begin
               vu_ff[k+1] <= vu_ff[k] - (vv_ff[k] >>> k);
               vv_ff[k+1] <= vv_ff[k] + (vu_ff[k] >>> k);
               vz_ff[k+1] <= vz_ff[k] - VZ_W'(atan_tab(k));
            end
            vzero_ff[k+1] <= vzero_ff[k];
         end

         fm1_ff    <= fr_in[DIV_PRE +: DIV_M_W];
         fzero1_ff <= vzero_ff[S];

         fm2_ff    <= fm1_ff;
         fp2_ff    <= DIV_P_W'(fm1_ff) * DIV_P_W'(DIV_MUL);
         fzero2_ff <= fzero1_ff;

         az_ff <= az_in;
      end
   end

endmodule

[tb/bearing_checker.sv]
// bearing_checker: watches the request and response channels of
// great_circle_bearing, predicts each azimuth and compares. Uses gcb_pkg.
`timescale 1ns / 1ps
module bearing_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [30:0] req_target_latitude,
   input  logic signed [31:0] req_target_longitude,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [15:0]        rsp_azimuth_centideg,
   output int                 fail_count,
   output int                 pending_count
);
   import gcb_pkg::*;

   localparam int STEPS = CORDIC_STEPS_DEF;
   localparam int FB    = FRAC_BITS_DEF;
   localparam longint D90  = 64'sd900000000;
   localparam longint D180 = 64'sd1800000000;
   localparam longint D360 = 64'sd3600000000;

   logic signed [30:0] base_lat;
   logic signed [31:0] base_lon;
   logic [15:0]        azimuth_q[$];

   function automatic longint fix_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
   endfunction

   function automatic longint wrap_half(longint a);
      longint r;
      r = a % D360;
      if (r >= D180) r -= D360;
      if (r < -D180) r += D360;
      return r;
   endfunction

   function automatic void sin_cos(input longint ang, output longint s,
                                   output longint c);
      longint a, x, y, z, dx, dy;
      bit flip;
      a = wrap_half(ang);
      flip = 0;
      if (a > D90) begin
         a -= D180;
         flip = 1;
      end else if (a < -D90) begin
         a += D180;
         flip = 1;
      end
      x = longint'((INV_GAIN_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
      y = 0;
      z = a;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_tab(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_tab(i));
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint heading(longint east, longint north);
      longint u, v, z, du, dv, r;
      u = north; v = east; z = 0;
      if (u < 0) begin
         u = -u; v = -v; z = D180;
      end
      for (int i = 0; i < STEPS; i++) begin
         du = v >>> i;
         dv = u >>> i;
         if (v >= 0) begin
            u += du; v -= dv; z += longint'(atan_tab(i));
         end else begin
            u -= du; v += dv; z -= longint'(atan_tab(i));
         end
      end
      r = z % D360;
      if (r < 0) r += D360;
      return r;
   endfunction

   function automatic logic [15:0] predict_azimuth(longint lat2, longint lon2);
      longint lat1, dlon, s1, c1, s2, c2, sd, cd, x, y, cd100;
      lat1 = longint'(base_lat);
      dlon = wrap_half(lon2 - longint'(base_lon));
      if (lat1 == lat2 && dlon == 0) return 16'd0;
      sin_cos(lat1, s1, c1);
      sin_cos(lat2, s2, c2);
      sin_cos(dlon, sd, cd);
      x = fix_mul(sd, c2);
      y = fix_mul(c1, s2) - fix_mul(fix_mul(s1, c2), cd);
      if (x == 0 && y == 0) return 16'd0;
      cd100 = (heading(x, y) + 50000) / 100000;
      if (cd100 >= 36000) cd100 = 0;
      return cd100[15:0];
   endfunction

   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         base_lat      <= '0;
         base_lon      <= '0;
         fail_count    <= 0;
         pending_count <= 0;
         azimuth_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_BASE_LAT) base_lat <= csr_wdata[30:0];
            else if (csr_index == CSR_BASE_LON) base_lon <= csr_wdata;
         end
         if (req_valid && !req_stall)
            azimuth_q.push_back(predict_azimuth(longint'(req_target_latitude),
                                                longint'(req_target_longitude)));
         if (rsp_valid && !rsp_stall) begin
            if (azimuth_q.size() == 0) begin
               $display("%0t: unexpected response, actual %0d", $time,
                        rsp_azimuth_centideg);
               fail_count <= fail_count + 1;
            end else begin
               want = azimuth_q.pop_front();
               if (rsp_azimuth_centideg !== want) begin
                  $display("%0t: azimuth expected %0d actual %0d", $time, want,
                           rsp_azimuth_centideg);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= azimuth_q.size();
      end
   end
endmodule

[tb/testbench.sv]
// testbench: stimulus and verdict for great_circle_bearing; the checking
// lives in bearing_checker. Depends on gcb_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
   import gcb_pkg::*;

   localparam int LATENCY   = 2 * CORDIC_STEPS_DEF + 10;
   localparam int IDLE_STOP = 20000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic signed [30:0] req_target_latitude;
   logic signed [31:0] req_target_longitude;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [15:0]        rsp_azimuth_centideg;
   int                 fail_count;
   int                 pending_count;
   int                 idle_cycles;
   bit                 stim_done;

   great_circle_bearing u_dut (.*);

   bearing_checker u_check (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Response-side stall, random with bursts; calm stretches when calm_rsp.
   bit calm_rsp;
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (calm_rsp || $urandom_range(3) != 0) begin
            rsp_stall <= 0;
         end else begin
            n = 1 + pick_gap();
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // Watchdog: cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (pending_count > 0 || !stim_done)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_STOP) begin
         $display("great_circle_bearing: mismatch");
         $finish;
      end
   end

   // One request; gap of idle cycles first unless calm.
   task automatic send_target(input logic signed [30:0] lat,
                              input logic signed [31:0] lon, input bit calm);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1;
      req_target_latitude  <= lat;
      req_target_longitude <= lon;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_base(input csr_index_type idx, input logic [31:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 0;
      @(negedge clock);
   endtask

   // Drain the pipeline before touching the base registers.
   task automatic settle();
      req_valid <= 0;
      @(negedge clock);
      while (pending_count > 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic signed [30:0] any_lat();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 31'($urandom);       // out of range, full bit pattern
      if (r == 1) return $urandom_range(1) ? 31'sd900000000 : -31'sd900000000;
      return 31'($signed($urandom_range(1800000000)) - 32'sd900000000);
   endfunction

   function automatic logic signed [31:0] any_lon();
      int r;
      r = $urandom_range(9);
      if (r == 0) return $urandom;
      if (r == 1) return $urandom_range(1) ? 32'sd1800000000 : -32'sd1800000000;
      return $signed($urandom_range(2000000000) * 2 - 32'sd1800000000) / 1;
   endfunction

   // Same meridian as lon, one full turn away where that still fits.
   function automatic logic signed [31:0] same_lon(input logic signed [31:0] lon);
      longint alt;
      alt = longint'(lon) + ((lon < 0) ? 64'sd3600000000 : -64'sd3600000000);
      if (alt < -64'sd2147483648 || alt > 64'sd2147483647) return lon;
      return alt[31:0];
   endfunction

   logic signed [30:0] lat_base [6];
   logic signed [31:0] lon_base [6];

   initial begin
      csr_wr_en = 0;
      csr_index = CSR_BASE_LAT;
      csr_wdata = 0;
      req_valid = 0;
      req_target_latitude  = 0;
      req_target_longitude = 0;
      stim_done   = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: coincident point, poles, field extremes, antimeridian.
      send_target(0, 0, 1);                               // coincident with base
      send_target(31'sd900000000, 0, 1);                  // due north pole
      send_target(-31'sd900000000, 32'sd12345, 1);        // south pole
      send_target(0, 32'sd1800000000, 1);                 // antipodal
      send_target(0, -32'sd1800000000, 1);
      send_target(0, 32'sd3600000, 1);                    // due east
      send_target(0, -32'sd3600000, 1);                   // due west
      send_target(31'sh3fffffff, 32'sh7fffffff, 1);       // max bit patterns
      send_target(31'sh40000000, 32'sh80000000, 1);       // min bit patterns
      send_target(-31'sd1, -32'sd1, 1);
      send_target(31'sd1, 32'sd0, 1);
      send_target(0, -32'sd694967296, 0);                 // random gap ahead
      settle();
      // Unknown index is ignored by both sides.
      write_base(csr_index_type'(2'd3), 32'h1234_5678);
      write_base(CSR_BASE_LAT, 32'sd900000000);
      write_base(CSR_BASE_LON, 32'sd1800000000);
      send_target(31'sd900000000, -32'sd1800000000, 1);  // coincident at pole
      send_target(31'sd900000000, 32'sd5, 1);            // pole, zero vector
      send_target(-31'sd900000000, 0, 1);
      send_target(0, 0, 1);
      settle();

      lat_base = '{-31'sd900000000, 31'sd900000000, 31'sd475000000,
                   -31'sd337000000, 31'sh3fffffff, 31'sd0};
      lon_base = '{-32'sd1800000000, 32'sd1800000000, 32'sd85000000,
                   32'sh7fffffff, 32'sh80000000, -32'sd1220000000};
      for (int ph = 0; ph < 6; ph++) begin
         write_base(CSR_BASE_LAT, {1'b0, lat_base[ph]});
         write_base(CSR_BASE_LON, lon_base[ph]);
         calm_rsp = (ph == 2);
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(9) == 0)
               send_target(lat_base[ph], $urandom_range(1) ?
                           lon_base[ph] : same_lon(lon_base[ph]), ph == 2);
            else if ($urandom_range(4) == 0)  // near base, small offsets
               send_target(31'(lat_base[ph] + $signed($urandom_range(2000)) - 1000),
                           lon_base[ph] + $signed($urandom_range(2000)) - 1000,
                           ph == 2);
            else
               send_target(any_lat(), any_lon(), ph == 2 || k[4]);
         end
         calm_rsp = 0;
         settle();
      end

      stim_done = 1;
      if (fail_count == 0)
         $display("great_circle_bearing: match");
      else
         $display("great_circle_bearing: mismatch");
      $finish;
   end
endmodule
